/* sv/tsrb_pkg.sv */
// Package for the timestamped sample ring buffer.
// Holds field widths, action codes, status codes and run modes.
// No dependencies.
`timescale 1ns / 1ps

package tsrb_pkg;

  localparam int TS_W   = 48;
  localparam int CNT_W  = 13;
  localparam int SMP_W  = 32;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 3;
  localparam int MODE_W = 2;

  typedef logic [TS_W-1:0]   stamp_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [SMP_W-1:0]  word_t;
  typedef logic [ACT_W-1:0]  action_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam action_t ACT_WRITE_BEGIN  = 3'd0;
  localparam action_t ACT_WRITE_SAMPLE = 3'd1;
  localparam action_t ACT_READ_BEGIN   = 3'd2;
  localparam action_t ACT_READ_SAMPLE  = 3'd3;
  localparam action_t ACT_QUERY        = 3'd4;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_BAD_TIME  = 3'd1;
  localparam status_t ST_READ_ERR  = 3'd2;
  localparam status_t ST_WRITE_ERR = 3'd3;
  localparam status_t ST_OVERRUN   = 3'd4;

  localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

endpackage

/* sv/timestamped_sample_ring_buffer_unit.sv */
// Timestamped sample ring buffer: done rises in the cycle after start for every
// action, and one transaction may be started in every cycle (busy stays low).
// Read samples come from the registered read port of the ring RAM and appear
// with done. Reset clears times, indexes and the run state; ring contents
// are undefined until written. The receiver cannot stall the result strobe.
// Depends on tsrb_pkg and tsrb_ram.
`timescale 1ns / 1ps

module timestamped_sample_ring_buffer_unit
  import tsrb_pkg::*;
#(
  parameter int BUF_WORDS_LOG2 = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [ACT_W-1:0]     action,
  input  logic [TS_W-1:0]      timestamp,
  input  logic [CNT_W-1:0]     count,
  input  logic [SMP_W-1:0]     sample,
  output logic                 done,
  output logic [STAT_W-1:0]    status,
  output logic [SMP_W-1:0]     sample_out,
  output logic [TS_W-1:0]      amount,
  output logic                 last
);

  localparam int L     = BUF_WORDS_LOG2;
  localparam int SUM_W = (L >= CNT_W) ? L + 2 : CNT_W + 1;
  localparam logic [SUM_W-1:0] RING = SUM_W'(1) << L;

  stamp_t              oldest_time, oldest_time_next;
  stamp_t              newest_time, newest_time_next;
  logic [L-1:0]        oldest_index, oldest_index_next;
  logic [L-1:0]        newest_index, newest_index_next;
  logic [L-1:0]        run_pointer, run_pointer_next;
  count_t              run_remaining, run_remaining_next;
  logic [MODE_W-1:0]   run_mode, run_mode_next;

  status_t             status_next;
  stamp_t              amount_next;
  logic                last_next;
  logic                rd_sel, rd_sel_next;
  logic                ram_we;
  word_t               ram_q;

  logic                acc;
  logic [TS_W:0]       end_sum;
  logic [L-1:0]        start_pos;
  logic [SUM_W-1:0]    start_sum;
  logic [SUM_W-1:0]    cnt_ext;
  logic [L-1:0]        new_index;
  logic                run_ok;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  assign end_sum   = {1'b0, timestamp} + (TS_W + 1)'(count);
  assign start_pos = oldest_index + (timestamp[L-1:0] - oldest_time[L-1:0]);
  assign cnt_ext   = SUM_W'(count);
  assign start_sum = SUM_W'(start_pos) + cnt_ext;
  assign new_index = start_sum[L-1:0];
  assign run_ok    = (run_remaining != '0);

  always_comb begin
    oldest_time_next   = oldest_time;
    newest_time_next   = newest_time;
    oldest_index_next  = oldest_index;
    newest_index_next  = newest_index;
    run_pointer_next   = run_pointer;
    run_remaining_next = run_remaining;
    run_mode_next      = run_mode;
    status_next        = ST_OK;
    amount_next        = '0;
    last_next          = 1'b0;
    rd_sel_next        = 1'b0;
    ram_we             = 1'b0;
    if (acc) begin
      unique case (action)
        ACT_WRITE_BEGIN: begin
          if (count == '0 || cnt_ext >= RING) begin
            status_next = ST_WRITE_ERR;
          end else if (end_sum <= {1'b0, newest_time}) begin
            status_next = ST_BAD_TIME;
          end else begin
            newest_index_next  = new_index;
            newest_time_next   = end_sum[TS_W-1:0];
            run_mode_next      = MODE_WRITE;
            run_pointer_next   = start_pos;
            run_remaining_next = count;
            amount_next        = TS_W'(count);
            if (start_sum > RING && new_index > oldest_index) begin
              status_next = ST_OVERRUN;
            end else if (end_sum[TS_W-1:0] <= oldest_time) begin
              status_next = ST_WRITE_ERR;
            end
          end
        end
        ACT_WRITE_SAMPLE: begin
          if (run_mode != MODE_WRITE || !run_ok) begin
            status_next = ST_WRITE_ERR;
          end else begin
            ram_we             = 1'b1;
            run_pointer_next   = run_pointer + 1'b1;
            run_remaining_next = run_remaining - 1'b1;
            if (run_remaining == CNT_W'(1)) begin
              last_next     = 1'b1;
              run_mode_next = MODE_IDLE;
            end
          end
        end
        ACT_READ_BEGIN: begin
          if (timestamp < oldest_time) begin
            status_next = ST_BAD_TIME;
          end else if (timestamp >= newest_time) begin
            status_next = ST_OK;
          end else if (cnt_ext >= RING) begin
            status_next = ST_READ_ERR;
          end else begin
            run_pointer_next   = start_pos;
            run_remaining_next = count;
            run_mode_next      = (count != '0) ? MODE_READ : MODE_IDLE;
            oldest_index_next  = new_index;
            oldest_time_next   = end_sum[TS_W-1:0];
            if (end_sum > {1'b0, newest_time}) begin
              status_next = ST_READ_ERR;
              amount_next = newest_time - timestamp;
            end else begin
              amount_next = TS_W'(count);
            end
          end
        end
        ACT_READ_SAMPLE: begin
          if (run_mode != MODE_READ || !run_ok) begin
            status_next = ST_READ_ERR;
          end else begin
            rd_sel_next        = 1'b1;
            run_pointer_next   = run_pointer + 1'b1;
            run_remaining_next = run_remaining - 1'b1;
            if (run_remaining == CNT_W'(1)) begin
              last_next     = 1'b1;
              run_mode_next = MODE_IDLE;
            end
          end
        end
        ACT_QUERY: begin
          if (timestamp < oldest_time) begin
            status_next = ST_BAD_TIME;
          end else if (timestamp < newest_time) begin
            amount_next = newest_time - timestamp;
          end
        end
        default: begin
          status_next = ST_OK;
        end
      endcase
    end
  end

  tsrb_ram #(
    .WIDTH(SMP_W),
    .DEPTH(1 << BUF_WORDS_LOG2)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(run_pointer),
    .wdata(sample),
    .raddr(run_pointer),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_time   <= '0;
      newest_time   <= '0;
      oldest_index  <= '0;
      newest_index  <= '0;
      run_pointer   <= '0;
      run_remaining <= '0;
      run_mode      <= MODE_IDLE;
      done          <= 1'b0;
      rd_sel        <= 1'b0;
    end else begin
      oldest_time   <= oldest_time_next;
      newest_time   <= newest_time_next;
      oldest_index  <= oldest_index_next;
      newest_index  <= newest_index_next;
      run_pointer   <= run_pointer_next;
      run_remaining <= run_remaining_next;
      run_mode      <= run_mode_next;
      done          <= acc;
      rd_sel        <= rd_sel_next;
    end
  end

  always_ff @(posedge clk) begin
    status <= status_next;
    amount <= amount_next;
    last   <= last_next;
  end

  assign sample_out = rd_sel ? ram_q : '0;

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("done without a started transaction");

  a_last_with_done: assert property (@(posedge clk) disable iff (rst)
    last |-> done)
    else $error("last outside a result");

  a_read_word_with_done: assert property (@(posedge clk) disable iff (rst)
    rd_sel |-> done)
    else $error("ring word presented outside a result");

  a_idle_run_empty: assert property (@(posedge clk) disable iff (rst)
    (run_mode == MODE_IDLE) |-> (run_remaining == '0))
    else $error("idle run with samples left");

  a_active_run_nonempty: assert property (@(posedge clk) disable iff (rst)
    (run_mode != MODE_IDLE) |-> (run_remaining != '0))
    else $error("active run with no samples left");

  a_overrun_from_write_begin: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_OVERRUN) |-> $past(action == ACT_WRITE_BEGIN))
    else $error("overrun reported for an action other than write begin");

endmodule

/* sv/tsrb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tsrb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* dv/timestamped_sample_ring_buffer_unit_test.sv */
// Self-checking testbench for timestamped_sample_ring_buffer_unit: directed and random traffic
// from a queue-fed driver, a result monitor, and a transaction model of the ring and time marks.
// Depends on tsrb_pkg and the unit's RTL.
`timescale 1ns / 1ps

module timestamped_sample_ring_buffer_unit_test;
  import tsrb_pkg::*;

  localparam int BUF_WORDS_LOG2 = 12;
  localparam int RING = 1 << BUF_WORDS_LOG2;
  localparam int RANDOM_OPS = 700;
  localparam int CYCLE_LIMIT = 100000;
  localparam int PRINT_LIMIT = 40;
  localparam action_t ACT_RESERVED = 3'd7;

  typedef logic [BUF_WORDS_LOG2-1:0] slot_t;

  typedef struct packed {
    logic    hold;
    action_t action;
    stamp_t  ts;
    count_t  cnt;
    word_t   smp;
  } ring_op_t;

  typedef struct packed {
    status_t status;
    word_t   word;
    stamp_t  amount;
    logic    last;
  } ring_reply_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [ACT_W-1:0]  action = '0;
  logic [TS_W-1:0]   timestamp = '0;
  logic [CNT_W-1:0]  count = '0;
  logic [SMP_W-1:0]  sample = '0;
  logic              done;
  logic [STAT_W-1:0] status;
  logic [SMP_W-1:0]  sample_out;
  logic [TS_W-1:0]   amount;
  logic              last;

  // Copy 0 of the model shapes the stimulus; copy 1 predicts the results.
  stamp_t            oldest_t [2];
  stamp_t            newest_t [2];
  slot_t             oldest_i [2];
  slot_t             newest_i [2];
  slot_t             run_ptr [2];
  count_t            run_left [2];
  logic [MODE_W-1:0] run_mode [2];
  word_t             ring_word [2][RING];
  bit                ring_set [2][RING];

  ring_op_t    op_queue[$];
  ring_reply_t awaited_replies[$];
  ring_op_t    cur_op;
  bit          hold_next = 1'b0;
  int          scheduled = 0;
  int          mismatches = 0;
  int          replies_seen = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          ops_by_action [8];
  int          status_seen [8];

  timestamped_sample_ring_buffer_unit #(
    .BUF_WORDS_LOG2(BUF_WORDS_LOG2)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .timestamp(timestamp),
    .count(count),
    .sample(sample),
    .done(done),
    .status(status),
    .sample_out(sample_out),
    .amount(amount),
    .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic stamp_t rand_stamp();
    return stamp_t'({$urandom, $urandom});
  endfunction

  function automatic slot_t ring_slot(input int m, input stamp_t ts);
    stamp_t off;
    off = ts - oldest_t[m];
    return oldest_i[m] + off[BUF_WORDS_LOG2-1:0];
  endfunction

  function automatic ring_reply_t predict_reply(input int m, input ring_op_t op);
    ring_reply_t       r;
    logic [TS_W:0]     end_t;
    slot_t             first;
    stamp_t            avail;
    logic [MODE_W-1:0] want;
    r = '0;
    case (op.action)
      ACT_WRITE_BEGIN: begin
        end_t = {1'b0, op.ts} + (TS_W + 1)'(op.cnt);
        if (op.cnt == 0 || int'(op.cnt) >= RING) begin
          r.status = ST_WRITE_ERR;
        end else if (end_t <= {1'b0, newest_t[m]}) begin
          r.status = ST_BAD_TIME;
        end else begin
          first = ring_slot(m, op.ts);
          newest_i[m] = first + op.cnt[BUF_WORDS_LOG2-1:0];
          newest_t[m] = end_t[TS_W-1:0];
          run_mode[m] = MODE_WRITE;
          run_ptr[m] = first;
          run_left[m] = op.cnt;
          r.amount = stamp_t'(op.cnt);
          if (int'(first) + int'(op.cnt) > RING && newest_i[m] > oldest_i[m]) begin
            r.status = ST_OVERRUN;
          end else if (newest_t[m] <= oldest_t[m]) begin
            r.status = ST_WRITE_ERR;
          end
        end
      end
      ACT_WRITE_SAMPLE, ACT_READ_SAMPLE: begin
        want = (op.action == ACT_WRITE_SAMPLE) ? MODE_WRITE : MODE_READ;
        if (run_mode[m] != want || run_left[m] == 0) begin
          r.status = (op.action == ACT_WRITE_SAMPLE) ? ST_WRITE_ERR : ST_READ_ERR;
        end else begin
          if (op.action == ACT_WRITE_SAMPLE) begin
            ring_word[m][run_ptr[m]] = op.smp;
            ring_set[m][run_ptr[m]] = 1'b1;
          end else begin
            r.word = ring_word[m][run_ptr[m]];
          end
          run_ptr[m] = run_ptr[m] + 1'b1;
          run_left[m] = run_left[m] - 1'b1;
          if (run_left[m] == 0) begin
            r.last = 1'b1;
            run_mode[m] = MODE_IDLE;
          end
        end
      end
      ACT_READ_BEGIN: begin
        if (op.ts < oldest_t[m]) begin
          r.status = ST_BAD_TIME;
        end else if (op.ts < newest_t[m]) begin
          if (int'(op.cnt) >= RING) begin
            r.status = ST_READ_ERR;
          end else begin
            avail = newest_t[m] - op.ts;
            end_t = {1'b0, op.ts} + (TS_W + 1)'(op.cnt);
            first = ring_slot(m, op.ts);
            r.amount = (avail > stamp_t'(op.cnt)) ? stamp_t'(op.cnt) : avail;
            run_ptr[m] = first;
            run_left[m] = op.cnt;
            run_mode[m] = (op.cnt != 0) ? MODE_READ : MODE_IDLE;
            oldest_i[m] = first + op.cnt[BUF_WORDS_LOG2-1:0];
            oldest_t[m] = end_t[TS_W-1:0];
            if (end_t > {1'b0, newest_t[m]}) begin
              r.status = ST_READ_ERR;
            end
          end
        end
      end
      ACT_QUERY: begin
        if (op.ts < oldest_t[m]) begin
          r.status = ST_BAD_TIME;
        end else if (op.ts < newest_t[m]) begin
          r.amount = newest_t[m] - op.ts;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic schedule_op(input action_t act, input stamp_t ts, input count_t cnt,
                             input word_t smp);
    ring_op_t    op;
    ring_reply_t unused;
    op.hold = hold_next;
    op.action = act;
    op.ts = ts;
    op.cnt = cnt;
    op.smp = smp;
    // A read sample that would reach a ring entry never written becomes a query instead.
    if (act == ACT_READ_SAMPLE && run_mode[0] == MODE_READ && run_left[0] != 0 &&
        !ring_set[0][run_ptr[0]]) begin
      op.action = ACT_QUERY;
      op.ts = oldest_t[0];
    end
    hold_next = 1'b0;
    unused = predict_reply(0, op);
    op_queue.push_back(op);
    if (op.action <= ACT_QUERY) scheduled++;
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("Mismatch at cycle %0d on result %0d: %s is 0x%0h, expected 0x%0h",
               cycle_count, replies_seen, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        awaited_replies.push_back(predict_reply(1, cur_op));
        ops_by_action[cur_op.action]++;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (op_queue.size() != 0 &&
                   !(op_queue[0].hold && awaited_replies.size() != 0)) begin
        cur_op = op_queue.pop_front();
        action <= cur_op.action;
        timestamp <= cur_op.ts;
        count <= cur_op.cnt;
        sample <= cur_op.smp;
        start <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    ring_reply_t want;
    if (!rst && done) begin
      replies_seen++;
      status_seen[status]++;
      if (awaited_replies.size() == 0) begin
        flag_mismatch("unexpected result, status", 64'(status), '0);
      end else begin
        want = awaited_replies.pop_front();
        if (status !== want.status) begin
          flag_mismatch("status", 64'(status), 64'(want.status));
        end
        if (sample_out !== want.word) begin
          flag_mismatch("sample_out", 64'(sample_out), 64'(want.word));
        end
        if (amount !== want.amount) begin
          flag_mismatch("amount", 64'(amount), 64'(want.amount));
        end
        if (last !== want.last) flag_mismatch("last", 64'(last), 64'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, awaited_replies.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    stamp_t base;
    stamp_t ts;
    stamp_t avail;
    count_t cnt;
    int     pick;
    int     kind;
    int     n;
    int     first_random;
    bit     pressure_done;
    pressure_done = 1'b0;
    for (int m = 0; m < 2; m++) begin
      oldest_t[m] = '0;
      newest_t[m] = '0;
      oldest_i[m] = '0;
      newest_i[m] = '0;
      run_ptr[m] = '0;
      run_left[m] = '0;
      run_mode[m] = MODE_IDLE;
    end

    // Empty ring, sample moves outside a run, and both bad packet sizes.
    schedule_op(ACT_QUERY, '0, '0, '0);
    schedule_op(ACT_WRITE_SAMPLE, '0, '0, 32'hFFFF_FFFF);
    schedule_op(ACT_READ_SAMPLE, '0, '0, '0);
    schedule_op(ACT_WRITE_BEGIN, '0, '0, '0);
    schedule_op(ACT_WRITE_BEGIN, '0, count_t'(RING), '0);
    // A packet that wraps past the end of the ring, then a stale one.
    schedule_op(ACT_WRITE_BEGIN, 48'd4094, 13'd4, '0);
    schedule_op(ACT_WRITE_SAMPLE, '0, '0, '0);
    schedule_op(ACT_WRITE_SAMPLE, '0, '0, 32'hFFFF_FFFF);
    schedule_op(ACT_WRITE_SAMPLE, '0, '0, $urandom);
    schedule_op(ACT_WRITE_SAMPLE, '0, '0, $urandom);
    schedule_op(ACT_WRITE_BEGIN, '0, 13'd3, '0);
    schedule_op(ACT_QUERY, 48'd4095, '0, '0);
    // Reads: oversized request, a full read-back, early and empty requests.
    schedule_op(ACT_READ_BEGIN, 48'd4094, count_t'(RING), '0);
    schedule_op(ACT_READ_BEGIN, 48'd4094, 13'd4, '0);
    repeat (4) schedule_op(ACT_READ_SAMPLE, '0, '0, '0);
    schedule_op(ACT_READ_BEGIN, '0, 13'd1, '0);
    schedule_op(ACT_READ_BEGIN, 48'd4098, 13'd1, '0);
    schedule_op(ACT_QUERY, '0, '0, '0);
    // The end time wraps past the top of the time range; the run is then abandoned.
    schedule_op(ACT_WRITE_BEGIN, 48'hFFFF_FFFF_FFFE, 13'd3, '0);
    schedule_op(ACT_WRITE_SAMPLE, '0, '0, 32'hA5A5_5A5A);
    schedule_op(ACT_WRITE_BEGIN, 48'd4098, 13'd2, '0);
    schedule_op(ACT_QUERY, 48'hFFFF_FFFF_FFFF, 13'h1FFF, '0);
    schedule_op(ACT_READ_BEGIN, 48'd4098, '0, '0);
    schedule_op(ACT_READ_SAMPLE, '0, '0, '0);
    schedule_op(ACT_RESERVED, 48'hFFFF_FFFF_FFFF, 13'h1FFF, 32'hFFFF_FFFF);

    first_random = scheduled;
    while (scheduled - first_random < RANDOM_OPS) begin
      if (!pressure_done && scheduled - first_random >= RANDOM_OPS / 2) begin
        hold_next = 1'b1;
        pressure_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        base = (newest_t[0] >= oldest_t[0]) ? newest_t[0] : oldest_t[0];
        cnt = ($urandom_range(0, 19) == 0) ? count_t'($urandom_range(17, 160))
                                           : count_t'($urandom_range(1, 16));
        kind = $urandom_range(0, 19);
        ts = base;
        if (kind >= 13 && kind < 16) ts = base + stamp_t'($urandom_range(1, 8));
        else if (kind >= 16 && kind < 18) ts = base + stamp_t'($urandom_range(9, RING - 1));
        else if (kind == 18) ts = base - stamp_t'($urandom_range(0, 20));
        else if (kind == 19) cnt = $urandom_range(0, 1) ? count_t'(RING) : '0;
        schedule_op(ACT_WRITE_BEGIN, ts, cnt, $urandom);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, int'(cnt)) : int'(cnt);
        if (kind == 19) n = $urandom_range(0, 2);
        repeat (n) begin
          schedule_op(ACT_WRITE_SAMPLE, rand_stamp(), count_t'($urandom_range(0, RING)),
                      $urandom);
        end
      end else if (pick < 80) begin
        avail = (newest_t[0] > oldest_t[0]) ? newest_t[0] - oldest_t[0] : '0;
        kind = $urandom_range(0, 19);
        if (kind < 14) begin
          ts = oldest_t[0];
          if (avail != 0) begin
            ts = ts + stamp_t'($urandom_range(0, (avail > 8) ? 8 : int'(avail) - 1));
          end
        end else if (kind < 16) begin
          ts = oldest_t[0] - stamp_t'($urandom_range(1, 50));
        end else begin
          ts = newest_t[0] + stamp_t'($urandom_range(0, 3));
        end
        kind = $urandom_range(0, 19);
        if (kind == 0) cnt = '0;
        else if (kind == 1) cnt = count_t'(RING);
        else if (kind < 4 && avail < 200) cnt = count_t'(avail + $urandom_range(1, 8));
        else cnt = count_t'($urandom_range(1, 16));
        schedule_op(ACT_READ_BEGIN, ts, cnt, $urandom);
        n = (int'(cnt) >= RING) ? $urandom_range(0, 2) : int'(cnt);
        if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
        repeat (n) begin
          schedule_op(ACT_READ_SAMPLE, rand_stamp(), count_t'($urandom_range(0, RING)),
                      $urandom);
        end
      end else if (pick < 90) begin
        ts = oldest_t[0] + stamp_t'($urandom_range(0, 40)) - 48'd8;
        schedule_op(ACT_QUERY, ts, count_t'($urandom_range(0, RING)), $urandom);
      end else begin
        schedule_op(action_t'($urandom_range(0, 7)), rand_stamp(),
                    count_t'($urandom_range(0, RING)), $urandom);
      end
    end

    wait (rst == 1'b0);
    while (op_queue.size() != 0 || start || awaited_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Sent %0d write begins, %0d write samples, %0d read begins, %0d read samples,"
             , ops_by_action[ACT_WRITE_BEGIN], ops_by_action[ACT_WRITE_SAMPLE],
             ops_by_action[ACT_READ_BEGIN], ops_by_action[ACT_READ_SAMPLE]);
    $display({"%0d queries; %0d results: %0d ok, %0d bad time, %0d read err, ",
              "%0d write err, %0d overrun"},
             ops_by_action[ACT_QUERY], replies_seen, status_seen[ST_OK],
             status_seen[ST_BAD_TIME], status_seen[ST_READ_ERR], status_seen[ST_WRITE_ERR],
             status_seen[ST_OVERRUN]);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/tsrb_pkg.sv
sv/tsrb_ram.sv
sv/timestamped_sample_ring_buffer_unit.sv
dv/timestamped_sample_ring_buffer_unit_test.sv
